FILE: sv/bda_pkg.sv
// ============================================================================
// bda_pkg: shared types and constants of the decimal ASCII writer
// Command and status structs between the controller and the datapath, the
// default operand width and the character constants.
// ============================================================================
package bda_pkg;

    localparam int VALUE_WIDTH_DEFAULT = 32;
    localparam int DIGIT_WIDTH         = 4;
    localparam int CHAR_WIDTH          = 6;

    localparam logic [CHAR_WIDTH-1:0] ASCII_ZERO = 6'd48;

    // Commands from the controller to the datapath, at most one high per cycle.
    typedef struct packed {
        logic load;
        logic shift;
        logic skip;
        logic emit;
    } t_cmd;

    // Status from the datapath back to the controller.
    typedef struct packed {
        logic shift_done;
        logic top_zero;
        logic one_left;
        logic out_free;
    } t_status;

endpackage

FILE: sv/bda_ctrl.sv
// ============================================================================
// bda_ctrl: sequencing state machine of the decimal ASCII writer
// Steps one number through conversion, leading zero suppression and digit
// emission, issuing at most one command a cycle to the datapath.
// ============================================================================
module bda_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  bda_pkg::t_status i_status,
    output bda_pkg::t_cmd    o_cmd
);
    import bda_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_CONV = 4'b0010,
        S_SKIP = 4'b0100,
        S_EMIT = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CONV;
                end
            end
            S_CONV: begin
                o_cmd.shift = 1'b1;
                if (i_status.shift_done) begin
                    n_state = S_SKIP;
                end
            end
            S_SKIP: begin
                if (i_status.top_zero && !i_status.one_left) begin
                    o_cmd.skip = 1'b1;
                end else begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (i_status.one_left) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

FILE: sv/bda_datapath.sv
// ============================================================================
// bda_datapath: shift-add-3 converter and digit output register
// Holds the binary operand and the BCD accumulator, the shift and digit
// counters, and the registered output character.
// ============================================================================
module bda_datapath #(
    parameter int VALUE_WIDTH = bda_pkg::VALUE_WIDTH_DEFAULT
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic [VALUE_WIDTH-1:0]         i_value,
    input  bda_pkg::t_cmd                  i_cmd,
    output bda_pkg::t_status               o_status,
    input  logic                           i_ready,
    output logic                           o_valid,
    output logic [bda_pkg::CHAR_WIDTH-1:0] o_digit_char,
    output logic                           o_last_digit
);
    import bda_pkg::*;

    // Decimal digits of the largest operand: floor(W * log10(2)) + 1.
    localparam int NUM_DIGITS = (VALUE_WIDTH * 30103) / 100000 + 1;
    localparam int BCD_WIDTH  = NUM_DIGITS * DIGIT_WIDTH;
    localparam int SH_WIDTH   = (VALUE_WIDTH > 1) ? $clog2(VALUE_WIDTH) : 1;
    localparam int LEFT_WIDTH = $clog2(NUM_DIGITS + 1);

    logic [VALUE_WIDTH-1:0] r_bin;
    logic [BCD_WIDTH-1:0]   r_bcd;
    logic [BCD_WIDTH-1:0]   n_bcd_adj;
    logic [SH_WIDTH-1:0]    r_sh_cnt;
    logic [LEFT_WIDTH-1:0]  r_left;
    logic                   r_out_valid;
    logic [CHAR_WIDTH-1:0]  r_out_char;
    logic                   r_out_last;
    logic [DIGIT_WIDTH-1:0] w_top;

    assign w_top = r_bcd[BCD_WIDTH-1 -: DIGIT_WIDTH];

    // Add three to every digit of five or more before the shift.
    always_comb begin
        for (int d = 0; d < NUM_DIGITS; d++) begin
            if (r_bcd[d*DIGIT_WIDTH +: DIGIT_WIDTH] >= DIGIT_WIDTH'(5)) begin
                n_bcd_adj[d*DIGIT_WIDTH +: DIGIT_WIDTH] =
                    r_bcd[d*DIGIT_WIDTH +: DIGIT_WIDTH] + DIGIT_WIDTH'(3);
            end else begin
                n_bcd_adj[d*DIGIT_WIDTH +: DIGIT_WIDTH] =
                    r_bcd[d*DIGIT_WIDTH +: DIGIT_WIDTH];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_bin    <= i_value;
            r_bcd    <= '0;
            r_sh_cnt <= '0;
            r_left   <= LEFT_WIDTH'(NUM_DIGITS);
        end else if (i_cmd.shift) begin
            r_bin    <= {r_bin[VALUE_WIDTH-2:0], 1'b0};
            r_bcd    <= {n_bcd_adj[BCD_WIDTH-2:0], r_bin[VALUE_WIDTH-1]};
            r_sh_cnt <= r_sh_cnt + SH_WIDTH'(1);
        end else if (i_cmd.skip || i_cmd.emit) begin
            r_bcd  <= {r_bcd[BCD_WIDTH-DIGIT_WIDTH-1:0], {DIGIT_WIDTH{1'b0}}};
            r_left <= r_left - LEFT_WIDTH'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_char <= ASCII_ZERO + CHAR_WIDTH'(w_top);
            r_out_last <= (r_left == LEFT_WIDTH'(1));
        end
    end

    assign o_status.shift_done = (r_sh_cnt == SH_WIDTH'(VALUE_WIDTH - 1));
    assign o_status.top_zero   = (w_top == '0);
    assign o_status.one_left   = (r_left == LEFT_WIDTH'(1));
    assign o_status.out_free   = !r_out_valid || i_ready;

    assign o_valid      = r_out_valid;
    assign o_digit_char = r_out_char;
    assign o_last_digit = r_out_last;

endmodule

FILE: sv/binary_to_decimal_ascii.sv
// ============================================================================
// binary_to_decimal_ascii: unsigned binary to ASCII decimal digit writer
// Sequence: after acceptance the operand is shifted in bit by bit, then each
// suppressed leading zero is dropped in turn and a decision step precedes the
// first digit; the rest follow one a cycle while the output keeps up.
// Pacing: a new number is accepted only once the last digit of the previous
// one is emitted, as set by the bit-serial shift-add-3 loop and the digit
// loop; output stalls lengthen this.
// Reset: synchronous, active low; returns the controller to idle and empties
// the output register. No state is kept between numbers.
// ============================================================================
module binary_to_decimal_ascii #(
    parameter int VALUE_WIDTH = bda_pkg::VALUE_WIDTH_DEFAULT
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // Input channel: one number per transaction.
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic [VALUE_WIDTH-1:0]         i_value,
    // Output channel: one ASCII digit per transaction, most significant first.
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic [bda_pkg::CHAR_WIDTH-1:0] o_digit_char,
    output logic                           o_last_digit
);
    import bda_pkg::*;

    // The controller accepts a number only when idle. It then shifts the
    // operand through the BCD accumulator one bit a cycle, with add-three
    // correction on every digit. Afterwards the leading zero digits are
    // shifted out one a cycle, stopping at the first non-zero digit or at
    // the last digit, so that zero still yields a single '0'. The remaining
    // digits leave through a registered output stage; the next number may be
    // accepted while the final digit of the previous one still waits there.

    t_cmd    w_cmd;
    t_status w_status;

    bda_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_status (w_status),
        .o_cmd    (w_cmd)
    );

    bda_datapath #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_value      (i_value),
        .i_cmd        (w_cmd),
        .o_status     (w_status),
        .i_ready      (i_ready),
        .o_valid      (o_valid),
        .o_digit_char (o_digit_char),
        .o_last_digit (o_last_digit)
    );

endmodule
